### hw/rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Types and constants shared by the move range coalescer and its checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int BATCH_DEPTH = 32;
  localparam int CNT_W       = $clog2(BATCH_DEPTH + 1);
  localparam int IDX_W       = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;

  localparam int CL_W    = 32;
  localparam int CB_W    = 26;
  localparam int MOVED_W = 33;
  localparam int BYTES_W = 57;
  localparam int PROD_W  = MOVED_W + CB_W;

  localparam int          CFG_IDX_W     = 2;
  localparam logic [1:0]  CFG_LIVE      = 2'd0;
  localparam logic [1:0]  CFG_CLUSTER   = 2'd1;
  localparam logic [1:0]  CFG_OBJ_TOTAL = 2'd2;
  localparam int          CFG_DATA_W    = 32;

  localparam logic [CB_W-1:0] CB_RESET = 26'd4096;
  localparam logic [CL_W-1:0] CL_BASE  = 32'd2;

  typedef struct packed {
    logic            mode;
    logic [CL_W-1:0] src_cl;
    logic [CL_W-1:0] dst_cl;
  } mrc_in_t;

  typedef struct packed {
    logic [BYTES_W-1:0] source_bytes;
    logic [BYTES_W-1:0] target_bytes;
    logic [BYTES_W-1:0] length_bytes;
    logic [BYTES_W-1:0] moved_bytes;
    logic [31:0]        obj_done;
    logic [31:0]        objects_all;
    logic [31:0]        batch_number;
    logic               last_in_batch;
  } mrc_out_t;

endpackage

### hw/rtl/move_range_coalescer.sv
// ----------------------------------------------------------------------------
// move_range_coalescer
// Merges cluster moves into runs and reports buffered runs in batches as
// byte offsets, scaled by one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | mrc_in_t
//  out_    | output    | out_valid / out_ready | mrc_out_t, one item per run
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  an input item is accepted in S_IDLE, then updates counters and buffer in S_EXEC
//  an emitting item then passes S_MOVED once per batch and S_MUL_SRC,
//  S_MUL_TGT, S_MUL_LEN and S_OUT per buffered run, with S_READ between runs:
//  the run store is read one entry at a time and the single 33x26 multiplier
//  scales three values per run plus the moved total once per batch
//  reset is synchronous; the run store needs no clearing pass
//  a stalled out_ready holds the emission in its output stage
module move_range_coalescer
  import mrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mrc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mrc_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_MOVED   = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_MUL_SRC = 3'd4;
  localparam logic [2:0] S_MUL_TGT = 3'd5;
  localparam logic [2:0] S_MUL_LEN = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  localparam int ENT_W = 3 * CL_W;

  logic [2:0]         state_r, state_nxt;
  mrc_in_t            item_r, item_nxt;
  logic               live_r;
  logic [CB_W-1:0]    cb_r;
  logic [31:0]        obj_total_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [MOVED_W-1:0] moved_r, moved_nxt;
  logic [31:0]        obj_r, obj_nxt;
  logic [31:0]        batch_r, batch_nxt;
  logic [31:0]        done_r, done_nxt;
  logic [CL_W-1:0]    last_src_r, last_src_nxt;
  logic [CL_W-1:0]    last_tgt_r, last_tgt_nxt;
  logic [CL_W-1:0]    last_len_r, last_len_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BYTES_W-1:0] mov_b_r, mov_b_nxt;
  logic [BYTES_W-1:0] src_b_r, src_b_nxt;
  logic [BYTES_W-1:0] tgt_b_r, tgt_b_nxt;
  logic [BYTES_W-1:0] len_b_r, len_b_nxt;
  logic               out_valid_r, out_valid_nxt;
  mrc_out_t           out_data_r, out_data_nxt;

  logic [ENT_W-1:0]   mem [BATCH_DEPTH];
  logic [ENT_W-1:0]   rd_data_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;

  logic [MOVED_W-1:0] mul_a;
  logic [PROD_W-1:0]  prod;
  logic [CL_W-1:0]    sum_src, sum_tgt;
  logic [CNT_W-1:0]   count_m1, count_p1;
  logic [CL_W-1:0]    rd_src, rd_tgt, rd_len;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_src = rd_data_r[ENT_W-1 -: CL_W];
  assign rd_tgt = rd_data_r[2*CL_W-1 -: CL_W];
  assign rd_len = rd_data_r[CL_W-1:0];

  assign sum_src  = last_src_r + last_len_r;
  assign sum_tgt  = last_tgt_r + last_len_r;
  assign count_m1 = count_r - CNT_W'(1);
  assign count_p1 = count_r + CNT_W'(1);

  // shared multiplier, operand picked by the sequencer
  always_comb begin
    case (state_r)
      S_MUL_SRC: mul_a = {1'b0, rd_src - CL_BASE};
      S_MUL_TGT: mul_a = {1'b0, rd_tgt - CL_BASE};
      S_MUL_LEN: mul_a = {1'b0, rd_len};
      default:   mul_a = moved_r;
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(cb_r);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    moved_nxt     = moved_r;
    obj_nxt       = obj_r;
    batch_nxt     = batch_r;
    done_nxt      = done_r;
    last_src_nxt  = last_src_r;
    last_tgt_nxt  = last_tgt_r;
    last_len_nxt  = last_len_r;
    idx_nxt       = idx_r;
    mov_b_nxt     = mov_b_r;
    src_b_nxt     = src_b_r;
    tgt_b_nxt     = tgt_b_r;
    len_b_nxt     = len_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = {item_r.src_cl, item_r.dst_cl, CL_W'(1)};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
        if (item_r.mode) begin
          obj_nxt = obj_r + 32'd1;
          if (live_r && (count_r != '0)) begin
            done_nxt  = obj_r + 32'd1;
            batch_nxt = batch_r + 32'd1;
            state_nxt = S_MOVED;
          end
        end else if (item_r.src_cl != item_r.dst_cl) begin
          moved_nxt = moved_r + MOVED_W'(1);
          if (live_r) begin
            if ((count_r != '0) && (sum_src == item_r.src_cl)
                && (sum_tgt == item_r.dst_cl)) begin
              // run continues: lengthen the last entry
              wr_en        = 1'b1;
              wr_addr      = count_m1[IDX_W-1:0];
              wr_data      = {last_src_r, last_tgt_r, last_len_r + CL_W'(1)};
              last_len_nxt = last_len_r + CL_W'(1);
            end else begin
              wr_en        = 1'b1;
              last_src_nxt = item_r.src_cl;
              last_tgt_nxt = item_r.dst_cl;
              last_len_nxt = CL_W'(1);
              count_nxt    = count_p1;
              if (count_p1 == CNT_W'(BATCH_DEPTH)) begin
                done_nxt  = obj_r + 32'd1;
                batch_nxt = batch_r + 32'd1;
                state_nxt = S_MOVED;
              end
            end
          end
        end
      end
      S_MOVED: begin
        mov_b_nxt = prod[BYTES_W-1:0];
        state_nxt = S_MUL_SRC;
      end
      S_READ: begin
        state_nxt = S_MUL_SRC;
      end
      S_MUL_SRC: begin
        src_b_nxt = prod[BYTES_W-1:0];
        state_nxt = S_MUL_TGT;
      end
      S_MUL_TGT: begin
        tgt_b_nxt = prod[BYTES_W-1:0];
        state_nxt = S_MUL_LEN;
      end
      S_MUL_LEN: begin
        len_b_nxt = prod[BYTES_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.source_bytes  = src_b_r;
          out_data_nxt.target_bytes  = tgt_b_r;
          out_data_nxt.length_bytes  = len_b_r;
          out_data_nxt.moved_bytes   = mov_b_r;
          out_data_nxt.obj_done      = done_r;
          out_data_nxt.objects_all   = obj_total_r;
          out_data_nxt.batch_number  = batch_r;
          out_data_nxt.last_in_batch = (CNT_W'(idx_r) == count_m1);
          if (CNT_W'(idx_r) == count_m1) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      moved_r     <= '0;
      obj_r       <= '0;
      batch_r     <= '0;
      out_valid_r <= 1'b0;
      live_r      <= 1'b1;
      cb_r        <= CB_RESET;
      obj_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      moved_r     <= moved_nxt;
      obj_r       <= obj_nxt;
      batch_r     <= batch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LIVE:      live_r      <= cfg_data[0];
          CFG_CLUSTER:   cb_r        <= cfg_data[CB_W-1:0];
          CFG_OBJ_TOTAL: obj_total_r <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    done_r     <= done_nxt;
    last_src_r <= last_src_nxt;
    last_tgt_r <= last_tgt_nxt;
    last_len_r <= last_len_nxt;
    idx_r      <= idx_nxt;
    mov_b_r    <= mov_b_nxt;
    src_b_r    <= src_b_nxt;
    tgt_b_r    <= tgt_b_nxt;
    len_b_r    <= len_b_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks for the move range coalescer, bound to the top level.
// ----------------------------------------------------------------------------
module mrc_checker
  import mrc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input mrc_out_t out_data
);

  // an accepted item always leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // no new item while a batch is still being delivered
  a_no_accept_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_in_batch |-> !in_ready)
    else $error("in_ready high in the middle of a batch");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind move_range_coalescer mrc_checker u_mrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/tb_move_range_coalescer.sv
// ----------------------------------------------------------------------------
// tb_move_range_coalescer
// Self-checking bench for the move range coalescer. A scoreboard class keeps
// its own copy of the run buffer, the counters and the registers, predicts
// every reported range from each accepted item and checks the results in
// order. Directed corner items come first, then random phases of runs, noise,
// self moves and end-of-object markers under several register settings, with
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_move_range_coalescer
  import mrc_pkg::*;
;

  class coalesce_scoreboard;
    logic [CL_W-1:0]    run_src [BATCH_DEPTH];
    logic [CL_W-1:0]    run_tgt [BATCH_DEPTH];
    logic [CL_W-1:0]    run_len [BATCH_DEPTH];
    int unsigned        run_count;
    logic [MOVED_W-1:0] moved_cnt;
    logic [31:0]        objects_seen;
    logic [31:0]        batch_seq;
    logic               live;
    logic [CB_W-1:0]    cb_bytes;
    logic [31:0]        object_total;
    mrc_out_t           expected_ranges[$];
    int unsigned        mismatches;

    function new();
      run_count    = 0;
      moved_cnt    = '0;
      objects_seen = '0;
      batch_seq    = '0;
      live         = 1'b1;
      cb_bytes     = CB_RESET;
      object_total = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LIVE:      live = val[0];
        CFG_CLUSTER:   cb_bytes = val[CB_W-1:0];
        CFG_OBJ_TOTAL: object_total = val;
        default: ;
      endcase
    endfunction

    function logic [BYTES_W-1:0] to_bytes(logic [MOVED_W-1:0] count);
      logic [PROD_W-1:0] prod;
      prod = count * cb_bytes;
      return prod[BYTES_W-1:0];
    endfunction

    function void emit_batch(logic [31:0] done);
      mrc_out_t        r;
      logic [CL_W-1:0] offs;
      if (run_count == 0) return;
      batch_seq = batch_seq + 1;
      for (int i = 0; i < run_count; i++) begin
        offs = run_src[i] - CL_BASE;
        r.source_bytes = to_bytes(offs);
        offs = run_tgt[i] - CL_BASE;
        r.target_bytes = to_bytes(offs);
        r.length_bytes = to_bytes(run_len[i]);
        r.moved_bytes = to_bytes(moved_cnt);
        r.obj_done = done;
        r.objects_all = object_total;
        r.batch_number = batch_seq;
        r.last_in_batch = (i == run_count - 1);
        expected_ranges.push_back(r);
      end
      run_count = 0;
    endfunction

    function void note_move(mrc_in_t x);
      logic [CL_W-1:0] src_next;
      logic [CL_W-1:0] tgt_next;
      int unsigned     k;
      if (x.mode) begin
        objects_seen = objects_seen + 1;
        if (live && run_count != 0) emit_batch(objects_seen);
        return;
      end
      if (x.src_cl == x.dst_cl) return;
      moved_cnt = moved_cnt + 1;
      if (!live) return;
      if (run_count != 0) begin
        k = run_count - 1;
        src_next = run_src[k] + run_len[k];
        tgt_next = run_tgt[k] + run_len[k];
        if (src_next == x.src_cl && tgt_next == x.dst_cl) begin
          run_len[k] = run_len[k] + 1;
          return;
        end
      end
      if (run_count >= BATCH_DEPTH) run_count = 0;
      run_src[run_count] = x.src_cl;
      run_tgt[run_count] = x.dst_cl;
      run_len[run_count] = 1;
      run_count++;
      if (run_count == BATCH_DEPTH) emit_batch(objects_seen + 1);
    endfunction

    function void cmp_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_range(mrc_out_t got);
      mrc_out_t want;
      if (expected_ranges.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected range, expected none, actual %h", $time, got);
        return;
      end
      want = expected_ranges.pop_front();
      cmp_field("source_bytes", want.source_bytes, got.source_bytes);
      cmp_field("target_bytes", want.target_bytes, got.target_bytes);
      cmp_field("length_bytes", want.length_bytes, got.length_bytes);
      cmp_field("moved_bytes", want.moved_bytes, got.moved_bytes);
      cmp_field("obj_done", want.obj_done, got.obj_done);
      cmp_field("objects_all", want.objects_all, got.objects_all);
      cmp_field("batch_number", want.batch_number, got.batch_number);
      cmp_field("last_in_batch", want.last_in_batch, got.last_in_batch);
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  mrc_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  mrc_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  coalesce_scoreboard sb;
  bit                 calm;

  move_range_coalescer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // result side: check accepted ranges, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_range(out_data);
    if (!calm && $urandom_range(99) < 24) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic mrc_in_t mk_item(logic m, logic [CL_W-1:0] s, logic [CL_W-1:0] t);
    mrc_in_t x;
    x.mode = m;
    x.src_cl = s;
    x.dst_cl = t;
    return x;
  endfunction

  function automatic logic [CL_W-1:0] pick_cluster();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'd1;
      2:       return CL_BASE;
      3:       return 32'hFFFF_FFFF - $urandom_range(3);
      4:       return $urandom_range(1000, 2);
      default: return $urandom;
    endcase
  endfunction

  // valid stays high after acceptance; the next call or drain decides
  task automatic send_item(input mrc_in_t x);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_move(x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic live, input logic [CB_W-1:0] cb,
                           input logic [31:0] total);
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0]  idxs [3];
    vals[0] = {31'd0, live};     idxs[0] = CFG_LIVE;
    vals[1] = {6'd0, cb};        idxs[1] = CFG_CLUSTER;
    vals[2] = total;             idxs[2] = CFG_OBJ_TOTAL;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned flush_pct,
                              input bit hold_mid);
    int unsigned     sent;
    int unsigned     pick;
    int unsigned     span;
    bit              paused;
    logic [CL_W-1:0] s;
    logic [CL_W-1:0] t;
    mrc_in_t         item;
    sent = 0;
    paused = 0;
    while (sent < count) begin
      if (hold_mid && !paused && sent >= count / 2) begin
        paused = 1;
        drain();
      end
      pick = $urandom_range(99);
      if (pick < flush_pct) begin
        send_item(mk_item(1'b1, $urandom, $urandom));
        sent++;
      end else if (pick < flush_pct + 5) begin
        // move onto itself, ignored by the block
        s = pick_cluster();
        send_item(mk_item(1'b0, s, s));
      end else begin
        span = (pick < flush_pct + 25) ? 1 : $urandom_range(8, 2);
        s = pick_cluster();
        t = pick_cluster();
        for (int k = 0; k < span; k++) begin
          item = mk_item(1'b0, s + k, t + k);
          // now and then break the run on one side only
          if ($urandom_range(19) == 0) begin
            if ($urandom_range(1)) item.dst_cl = item.dst_cl + 32'd7;
            else item.src_cl = item.src_cl + 32'd7;
          end
          send_item(item);
        end
        sent += span;
      end
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LIVE;
    cfg_data  = '0;
    calm      = 1'b0;
    sb        = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed corners under reset register values
    send_item(mk_item(1'b0, 32'd2, 32'd3));
    send_item(mk_item(1'b0, 32'd3, 32'd4));
    send_item(mk_item(1'b0, 32'd4, 32'd4));
    send_item(mk_item(1'b0, 32'd4, 32'd9));
    send_item(mk_item(1'b1, 32'd0, 32'd0));
    send_item(mk_item(1'b1, 32'd0, 32'd0));
    send_item(mk_item(1'b0, 32'd0, 32'hFFFF_FFFF));
    send_item(mk_item(1'b0, 32'd1, 32'd0));
    send_item(mk_item(1'b0, 32'hFFFF_FFFF, 32'd2));
    send_item(mk_item(1'b0, 32'd0, 32'd3));
    send_item(mk_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(1'b0, 32'd0, 32'd0));
    send_item(mk_item(1'b0, 32'hAAAA_AAAA, 32'h5555_5555));
    send_item(mk_item(1'b0, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(mk_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    configure(1'b1, 26'd512, 32'hFFFF_FFFF);
    random_phase(80, 8, 1'b0);
    drain();

    // no idling here, and no markers so full batches fire
    calm = 1'b1;
    configure(1'b1, 26'h3FF_FFFF, $urandom);
    random_phase(80, 0, 1'b0);
    drain();
    calm = 1'b0;

    // reporting off: counters move, buffered runs stay put
    configure(1'b0, 26'd33554432, 32'd0);
    random_phase(50, 10, 1'b0);
    drain();

    configure(1'b1, $urandom_range(33554432, 512), $urandom);
    random_phase(90, 5, 1'b1);
    drain();

    configure(1'b1, CB_RESET, $urandom);
    random_phase(70, 4, 1'b0);
    send_item(mk_item(1'b1, $urandom, $urandom));
    drain();

    if (sb.mismatches == 0 && sb.expected_ranges.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mrc_pkg.sv
hw/rtl/move_range_coalescer.sv
hw/rtl/mrc_checker.sv
test/tb_move_range_coalescer.sv
